>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the reporter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/bdjr_pkg.sv
// Shared constants and types of the button debounce and joystick reporter.
`timescale 1ns / 1ps
package bdjr_pkg;
   // Parameter defaults and limits.
   localparam int BUTTONS_DEFAULT  = 4;
   localparam int ADC_BITS_DEFAULT = 10;
   localparam int MAX_BUTTONS      = 8;
   localparam int MAX_ADC_BITS     = 16;
   localparam int ID_BUTTONS       = 4;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int THRESH_BITS    = 10;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PUBLISH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EVENT_IDS = 2'd3;

   // Register reset values.
   localparam logic [15:0]            DEBOUNCE_RESET  = 16'd20;
   localparam logic [15:0]            PUBLISH_RESET   = 16'd50;
   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 10'd4;
   localparam logic [31:0]            EVENT_IDS_RESET = 32'h0302_0005;

   // Result kinds.
   localparam logic [1:0] KIND_RELEASE = 2'd0;
   localparam logic [1:0] KIND_REPORT  = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // One classified poll, as the back needs it.
   typedef struct packed {
      logic [MAX_BUTTONS-1:0]  rel_mask;
      logic                    report;
      logic [MAX_ADC_BITS-1:0] x;
      logic [MAX_ADC_BITS-1:0] y;
      logic                    sw;
      logic                    led;
   } poll_type;

   // Queue status seen by the front, the back and the top level.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;
endpackage

>>> rtl/core/bdjr_req_if.sv
// Poll channel interface.
`timescale 1ns / 1ps
interface bdjr_req_if #(
   parameter int BUTTONS  = bdjr_pkg::BUTTONS_DEFAULT,
   parameter int ADC_BITS = bdjr_pkg::ADC_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [31:0]         now_ms;
   logic [BUTTONS-1:0]  buttons_pressed;
   logic [ADC_BITS-1:0] joy_x;
   logic [ADC_BITS-1:0] joy_y;
   logic                joy_switch;

   modport source (output valid, now_ms, buttons_pressed, joy_x, joy_y, joy_switch,
                   input ready);
   modport sink (input valid, now_ms, buttons_pressed, joy_x, joy_y, joy_switch,
                 output ready);
endinterface

>>> rtl/core/bdjr_rsp_if.sv
// Result channel interface.
`timescale 1ns / 1ps
interface bdjr_rsp_if #(
   parameter int ADC_BITS = bdjr_pkg::ADC_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [7:0]          event_id;
   logic [ADC_BITS-1:0] report_x;
   logic [ADC_BITS-1:0] report_y;
   logic                report_switch;
   logic                led;
   logic                last;

   modport source (output valid, kind, event_id, report_x, report_y, report_switch,
                   led, last, input ready);
   modport sink (input valid, kind, event_id, report_x, report_y, report_switch,
                 led, last, output ready);
endinterface

>>> rtl/core/bdjr_front.sv
// Front part: accepts polls, debounces buttons and decides on joystick reports.
`timescale 1ns / 1ps
module bdjr_front #(
   parameter int BUTTONS  = bdjr_pkg::BUTTONS_DEFAULT,
   parameter int ADC_BITS = bdjr_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bdjr_req_if.sink                             req_chan,
   input  logic [15:0]                          debounce_ms,
   input  logic [15:0]                          publish_interval_ms,
   input  logic [bdjr_pkg::THRESH_BITS-1:0]     delta_threshold,
   input  bdjr_pkg::q_status_type               q_status,
   output logic                                 push,
   output bdjr_pkg::poll_type                   poll
);
   localparam int CMP_W = (ADC_BITS > bdjr_pkg::THRESH_BITS) ? ADC_BITS
                                                              : bdjr_pkg::THRESH_BITS;

   logic [BUTTONS-1:0]  raw_ff, raw_in;
   logic [BUTTONS-1:0]  stable_ff, stable_in;
   logic [31:0]         stamp_ff [BUTTONS];
   logic [31:0]         stamp_in [BUTTONS];
   logic                have_ff;
   logic [ADC_BITS-1:0] prev_x_ff;
   logic [ADC_BITS-1:0] prev_y_ff;
   logic                prev_sw_ff;
   logic [31:0]         pub_ff, pub_in;

   logic [BUTTONS-1:0]  rel_mask;
   logic [31:0]         held;
   logic [ADC_BITS-1:0] dist_x, dist_y;
   logic [31:0]         since_pub;
   logic                changed, elapsed, report;

   // An item is taken whenever the queue has room.
   assign req_chan.ready = !q_status.full;
   assign push = req_chan.valid && !q_status.full;

   // Debounce every button in parallel: record change time, then promote to stable.
   always_comb begin
      raw_in    = req_chan.buttons_pressed;
      stable_in = stable_ff;
      rel_mask  = '0;
      held      = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         stamp_in[i] = (raw_in[i] != raw_ff[i]) ? req_chan.now_ms : stamp_ff[i];
         held = req_chan.now_ms - stamp_in[i];
         if ((held >= {16'd0, debounce_ms}) && (stable_ff[i] != raw_in[i])) begin
            stable_in[i] = raw_in[i];
            rel_mask[i]  = !raw_in[i];
         end
      end
   end

   // Joystick change and publish-interval checks.
   always_comb begin
      dist_x = (req_chan.joy_x >= prev_x_ff) ? (req_chan.joy_x - prev_x_ff)
                                             : (prev_x_ff - req_chan.joy_x);
      dist_y = (req_chan.joy_y >= prev_y_ff) ? (req_chan.joy_y - prev_y_ff)
                                             : (prev_y_ff - req_chan.joy_y);
      since_pub = req_chan.now_ms - pub_ff;
      changed = !have_ff
                || (CMP_W'(dist_x) >= CMP_W'(delta_threshold))
                || (CMP_W'(dist_y) >= CMP_W'(delta_threshold))
                || (req_chan.joy_switch != prev_sw_ff);
      elapsed = (pub_ff == 32'd0) || (since_pub >= {16'd0, publish_interval_ms});
      report  = (changed || elapsed) && !raw_in[0] && !stable_in[0];
      pub_in  = report ? req_chan.now_ms : pub_ff;
   end

   // Classified poll handed to the queue.
   always_comb begin
      poll          = '0;
      poll.rel_mask = bdjr_pkg::MAX_BUTTONS'(rel_mask);
      poll.report   = report;
      poll.x        = bdjr_pkg::MAX_ADC_BITS'(req_chan.joy_x);
      poll.y        = bdjr_pkg::MAX_ADC_BITS'(req_chan.joy_y);
      poll.sw       = req_chan.joy_switch;
      poll.led      = |stable_in;
   end

   // Poll state update on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff     <= '0;
         stable_ff  <= '0;
         have_ff    <= 1'b0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         prev_sw_ff <= 1'b0;
         pub_ff     <= '0;
         for (int i = 0; i < BUTTONS; i++) begin
            stamp_ff[i] <= '0;
         end
      end else if (push) begin
         raw_ff     <= raw_in;
         stable_ff  <= stable_in;
         have_ff    <= 1'b1;
         prev_x_ff  <= req_chan.joy_x;
         prev_y_ff  <= req_chan.joy_y;
         prev_sw_ff <= req_chan.joy_switch;
         pub_ff     <= pub_in;
         for (int i = 0; i < BUTTONS; i++) begin
            stamp_ff[i] <= stamp_in[i];
         end
      end
   end
endmodule

>>> rtl/core/bdjr_queue.sv
// Short queue of classified polls between the front and the back.
`timescale 1ns / 1ps
module bdjr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bdjr_pkg::poll_type     push_data,
   input  logic                   pop,
   output bdjr_pkg::poll_type     head,
   output bdjr_pkg::q_status_type status
);
   localparam int DEPTH = bdjr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bdjr_pkg::poll_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> rtl/core/bdjr_back.sv
// Back part: turns one classified poll into its result items, one per cycle while the result channel is ready.
`timescale 1ns / 1ps
module bdjr_back #(
   parameter int BUTTONS  = bdjr_pkg::BUTTONS_DEFAULT,
   parameter int ADC_BITS = bdjr_pkg::ADC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            button_event_ids,
   input  bdjr_pkg::poll_type     head,
   input  bdjr_pkg::q_status_type q_status,
   output logic                   pop,
   bdjr_rsp_if.source             rsp_chan
);
   localparam int IDS_W = 8 * bdjr_pkg::MAX_BUTTONS;

   // Poll being worked on.
   logic                busy_ff, busy_in;
   logic [BUTTONS-1:0]  mask_ff, mask_in;
   logic                rep_ff, rep_in;
   logic [ADC_BITS-1:0] x_ff, y_ff;
   logic                sw_ff, led_ff;

   // Output register.
   logic                out_valid_ff;
   logic [1:0]          kind_ff;
   logic [7:0]          id_ff;
   logic [ADC_BITS-1:0] rx_ff, ry_ff;
   logic                rsw_ff, rled_ff, last_ff;

   logic                advance, emit, emit_end;
   logic [BUTTONS-1:0]  lowest;
   logic [IDS_W-1:0]    ids_ext;
   logic [7:0]          id_sel;

   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign emit     = advance && busy_ff;
   assign emit_end = emit && (mask_ff == '0) && !rep_ff;
   assign pop      = !q_status.empty && (!busy_ff || emit_end);

   // Lowest pending release and its event id; buttons past the fourth have id 0.
   always_comb begin
      ids_ext = IDS_W'(button_event_ids);
      lowest  = mask_ff & (~mask_ff + 1'b1);
      id_sel  = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (lowest[i] && (i < bdjr_pkg::ID_BUTTONS)) begin
            id_sel = id_sel | ids_ext[8*i +: 8];
         end
      end
   end

   // Work register next values.
   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      rep_in  = rep_ff;
      if (emit) begin
         if (mask_ff != '0) begin
            mask_in = mask_ff & ~lowest;
         end else if (rep_ff) begin
            rep_in = 1'b0;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         mask_in = head.rel_mask[BUTTONS-1:0];
         rep_in  = head.report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mask_ff      <= '0;
         rep_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         mask_ff <= mask_in;
         rep_ff  <= rep_in;
         if (advance) begin
            out_valid_ff <= busy_ff;
         end
      end
   end

   // Poll payload and output payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff   <= head.x[ADC_BITS-1:0];
         y_ff   <= head.y[ADC_BITS-1:0];
         sw_ff  <= head.sw;
         led_ff <= head.led;
      end
      if (emit) begin
         rled_ff <= led_ff;
         id_ff   <= '0;
         rx_ff   <= '0;
         ry_ff   <= '0;
         rsw_ff  <= 1'b0;
         last_ff <= 1'b0;
         if (mask_ff != '0) begin
            kind_ff <= bdjr_pkg::KIND_RELEASE;
            id_ff   <= id_sel;
         end else if (rep_ff) begin
            kind_ff <= bdjr_pkg::KIND_REPORT;
            rx_ff   <= x_ff;
            ry_ff   <= y_ff;
            rsw_ff  <= sw_ff;
         end else begin
            kind_ff <= bdjr_pkg::KIND_END;
            last_ff <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = kind_ff;
   assign rsp_chan.event_id      = id_ff;
   assign rsp_chan.report_x      = rx_ff;
   assign rsp_chan.report_y      = ry_ff;
   assign rsp_chan.report_switch = rsw_ff;
   assign rsp_chan.led           = rled_ff;
   assign rsp_chan.last          = last_ff;
endmodule

>>> rtl/core/button_debounce_joystick_reporter.sv
// Flow: an accepted poll is written into the poll queue, taken into the back's work registers,
// and its result items leave one item per cycle through the back's output register while the
// result channel is ready; a poll yields n items (1 to BUTTONS + 2). The front takes a poll a
// cycle while the two-entry poll queue has room.
// Reset: synchronous, active high; clears debounce, joystick and queue state and
// loads the register defaults 20, 50, 4 and event ids 5, 0, 2, 3.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module button_debounce_joystick_reporter #(
   parameter int BUTTONS  = bdjr_pkg::BUTTONS_DEFAULT,
   parameter int ADC_BITS = bdjr_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   bdjr_req_if.sink                            req_chan,
   bdjr_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bdjr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdjr_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   logic [15:0]                      debounce_ff;
   logic [15:0]                      publish_ff;
   logic [bdjr_pkg::THRESH_BITS-1:0] threshold_ff;
   logic [31:0]                      event_ids_ff;

   logic                   push, pop;
   bdjr_pkg::poll_type     push_data, head;
   bdjr_pkg::q_status_type q_status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= bdjr_pkg::DEBOUNCE_RESET;
         publish_ff   <= bdjr_pkg::PUBLISH_RESET;
         threshold_ff <= bdjr_pkg::THRESHOLD_RESET;
         event_ids_ff <= bdjr_pkg::EVENT_IDS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bdjr_pkg::CSR_DEBOUNCE:  debounce_ff  <= csr_wr_data[15:0];
            bdjr_pkg::CSR_PUBLISH:   publish_ff   <= csr_wr_data[15:0];
            bdjr_pkg::CSR_THRESHOLD: threshold_ff <= csr_wr_data[bdjr_pkg::THRESH_BITS-1:0];
            bdjr_pkg::CSR_EVENT_IDS: event_ids_ff <= csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   bdjr_front #(.BUTTONS(BUTTONS), .ADC_BITS(ADC_BITS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_chan            (req_chan),
      .debounce_ms         (debounce_ff),
      .publish_interval_ms (publish_ff),
      .delta_threshold     (threshold_ff),
      .q_status            (q_status),
      .push                (push),
      .poll                (push_data)
   );

   bdjr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   bdjr_back #(.BUTTONS(BUTTONS), .ADC_BITS(ADC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .button_event_ids (event_ids_ff),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_chan         (rsp_chan)
   );

   // The queue can never report full and empty together.
   `ASSERT_IMPLIES(a_q_consistent, clock, reset, q_status.full, !q_status.empty)
   // An accepted item always leaves at least one poll queued.
   `ASSERT_NEXT(a_push_lands, clock, reset, push, !q_status.empty)
   // The closing flag marks exactly the poll-end items.
   `ASSERT_IMPLIES(a_last_on_end, clock, reset, rsp_chan.valid,
      rsp_chan.last == (rsp_chan.kind == bdjr_pkg::KIND_END))
   // Nothing is taken from an empty queue.
   `ASSERT_IMPLIES(a_no_empty_pop, clock, reset, pop, !q_status.empty)
endmodule
